@@ design/mva_pkg.sv @@
package mva_pkg;

  localparam int NUM_VOICES_DEF   = 18;
  localparam int NUM_CHANNELS_DEF = 16;

  localparam logic [13:0] BEND_CENTER  = 14'h2000;
  localparam logic [6:0]  CTRL_ALL_OFF = 7'd123;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_CONTROL  = 3'd2;
  localparam logic [2:0] KIND_PROGRAM  = 3'd3;
  localparam logic [2:0] KIND_BEND     = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;

  localparam logic [2:0] CMD_OFF    = 3'd0;
  localparam logic [2:0] CMD_TIMBRE = 3'd1;
  localparam logic [2:0] CMD_VOLUME = 3'd2;
  localparam logic [2:0] CMD_PITCH  = 3'd3;
  localparam logic [2:0] CMD_ON     = 3'd4;
  localparam int NUM_CMDS = 5;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] channel;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } msg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  voice;
    logic [13:0] value;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic        busy;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [31:0] age;
    logic [6:0]  volume;
  } voice_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_WRITE = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    M_FIND    = 2'd0,
    M_REL_ALL = 2'd1,
    M_REL_CH  = 2'd2,
    M_BEND    = 2'd3
  } mode_t;

  localparam logic signed [6:0] OCTAVE_SHIFT [128] = '{
    0, -12, 12, 0, 0, 12, -12, 0, 0, -24,
    0, 0, 0, 0, 0, 0, 0, 0, -12, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 12, 12, 12, 0, 0, 12, 12, 0,
    -12, -12, 0, 12, -12, -12, 0, 12, 0, 0,
    -12, 0, 0, 0, 12, 12, 0, 0, 12, 0,
    0, 0, 12, 0, 0, 0, 12, 12, 0, 12,
    0, 0, -12, 0, -12, -12, 0, 0, -12, -12,
    0, 0, 0, 0, 0, -12, -19, 0, 0, -12,
    0, 0, 0, 0, 0, 0, -31, -12, 0, 12,
    12, 12, 12, 0, 12, 0, 12, 0, 0, 0,
    0, 12, 0, 0, 0, 0, 12, 12, 12, 0,
    0, 0, 0, 0, -24, -36, 0, 0
  };

  function automatic logic [6:0] shift_note(input logic [6:0] patch, input logic [6:0] note);
    logic signed [8:0] sum;
    sum = $signed({2'b00, note}) + 9'(OCTAVE_SHIFT[patch]);
    if (sum < 0 || sum > 9'sd127) return note;
    return sum[6:0];
  endfunction

  function automatic logic [6:0] boost(input logic [6:0] vel);
    if (vel < 7'd2) return 7'd0;
    return 7'd64 + {1'b0, vel[6:1]};
  endfunction

endpackage

@@ design/midi_voice_allocator.sv @@
// channel | direction | handshake            | payload
// msg     | in        | msg_valid/msg_ready  | msg_t (kind, channel, data_one, data_two)
// cmd     | out       | cmd_valid/cmd_ready  | cmd_t (command, voice, value, last)
// cfg     | in        | cfg_we               | cfg_data (drum channel)
//
// one message at a time: one that causes nothing goes straight to done, a release or bend scan
// and an unmatched note off pass through scan and done, and a matched note off or a note on
// passes through scan, write, emit and done; the voice ring rotates one cell per cycle, held
// while the scan stalls, once to scan and once to write back
// synchronous reset clears the voice ring, channel tables and age counter at once
// a stalled cmd port holds the scan, emit and done steps once the one-deep hold stage is full
module midi_voice_allocator
  import mva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  msg_t       msg,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);

  state_t state;
  mode_t  mode;
  logic [3:0] drum_channel;

  // channel tables
  logic [6:0]  channel_patch [NUM_CHANNELS_DEF];
  logic [13:0] channel_bend  [NUM_CHANNELS_DEF];

  // latched message
  logic [3:0]  ch;
  logic        is_on;
  logic [6:0]  note_n;
  logic [6:0]  loud;
  logic [6:0]  patch_l;
  logic [13:0] bend_l;
  logic [13:0] bend_msg;
  logic [31:0] age_counter;

  // voice ring
  voice_t ring_q [NUM_VOICES];
  voice_t head, fb;
  logic   shift;
  logic [IW-1:0] idx;

  // scan tracking
  logic          found, found_next;
  logic [IW-1:0] fidx, fidx_next;
  logic [6:0]    fvol, fvol_next;
  logic          free, free_next;
  logic [IW-1:0] pick, pick_next;
  logic [6:0]    pnote, pnote_next;
  logic [6:0]    pvol, pvol_next;
  logic [31:0]   oldest, oldest_next;
  logic          b_found, b_free;
  logic [IW-1:0] b_fidx, b_pick;
  logic [6:0]    b_fvol, b_pnote, b_pvol;
  logic [31:0]   b_oldest;
  logic          match;

  // post-scan command list
  logic [IW-1:0] target;
  logic [4:0]    off_voice;
  logic [6:0]    off_note;
  logic [NUM_CMDS-1:0] mask;
  logic [NUM_CMDS-1:0] scan_mask;
  logic [2:0]    sel_cmd;

  // hold stage and output register
  logic        hold_valid;
  cmd_t        hold;
  logic        emit_req;
  cmd_t        emit_cmd;
  logic        can_push, stall, push, flush;

  genvar g;
  generate
    for (g = 0; g < NUM_VOICES; g++) begin : g_ring
      if (g == NUM_VOICES - 1) begin : g_tail
        mva_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(fb), .q(ring_q[g]));
      end else begin : g_mid
        mva_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring_q[g+1]),
                         .q(ring_q[g]));
      end
    end
  endgenerate

  assign head      = ring_q[0];
  assign msg_ready = (state == S_IDLE);
  assign bend_msg  = {msg.data_two, msg.data_one};
  assign can_push  = !cmd_valid || cmd_ready;
  assign match     = head.busy && head.note == note_n && head.channel == ch;

  // tracking starts fresh at voice 0
  always_comb begin
    if (idx == '0) begin
      b_found = 1'b0; b_fidx = '0; b_fvol = '0;
      b_free = 1'b0; b_pick = '0; b_pnote = head.note; b_pvol = head.volume;
      b_oldest = age_counter;
    end else begin
      b_found = found; b_fidx = fidx; b_fvol = fvol;
      b_free = free; b_pick = pick; b_pnote = pnote; b_pvol = pvol;
      b_oldest = oldest;
    end
    found_next = b_found || match;
    fidx_next  = (!b_found && match) ? idx : b_fidx;
    fvol_next  = (!b_found && match) ? head.volume : b_fvol;
    free_next = b_free; pick_next = b_pick; pnote_next = b_pnote; pvol_next = b_pvol;
    oldest_next = b_oldest;
    if (!b_free) begin
      if (!head.busy) begin
        free_next = 1'b1; pick_next = idx; pnote_next = head.note; pvol_next = head.volume;
      end else if (head.age < b_oldest) begin
        oldest_next = head.age; pick_next = idx;
        pnote_next = head.note; pvol_next = head.volume;
      end
    end
  end

  // commands owed once a note scan completes
  always_comb begin
    scan_mask = '0;
    if (found_next) begin
      scan_mask[CMD_OFF] = 1'b1;
      if (is_on) begin
        scan_mask[CMD_VOLUME] = (fvol_next != loud);
        scan_mask[CMD_PITCH]  = 1'b1;
        scan_mask[CMD_ON]     = 1'b1;
      end
    end else if (is_on) begin
      // new voice: first free, else oldest stolen
      scan_mask[CMD_OFF]    = !free_next;
      scan_mask[CMD_TIMBRE] = 1'b1;
      scan_mask[CMD_VOLUME] = (pvol_next != loud);
      scan_mask[CMD_PITCH]  = 1'b1;
      scan_mask[CMD_ON]     = 1'b1;
    end
  end

  // lowest pending command first
  always_comb begin
    sel_cmd = CMD_ON;
    for (int i = NUM_CMDS - 1; i >= 0; i--) begin
      if (mask[i]) sel_cmd = 3'(i);
    end
  end

  // command request and ring feedback
  always_comb begin
    emit_req = 1'b0;
    emit_cmd = '0;
    fb       = head;
    flush    = 1'b0;
    unique case (state)
      S_SCAN: begin
        unique case (mode)
          M_REL_ALL: begin
            emit_req = head.busy;
            emit_cmd = '{CMD_OFF, 5'(idx), {7'd0, head.note}, 1'b0};
            fb.busy  = 1'b0;
          end
          M_REL_CH: begin
            emit_req = head.busy && head.channel == ch;
            emit_cmd = '{CMD_OFF, 5'(idx), {7'd0, head.note}, 1'b0};
            if (head.channel == ch) fb.busy = 1'b0;
          end
          M_BEND: begin
            emit_req = head.busy && head.channel == ch;
            emit_cmd = '{CMD_PITCH, 5'(idx), bend_l, 1'b0};
          end
          default: ;
        endcase
      end
      S_WRITE: begin
        if (idx == target) begin
          fb.busy = is_on;
          fb.age  = age_counter;
          if (is_on) begin
            fb.note = note_n; fb.channel = ch; fb.volume = loud;
          end
        end
      end
      S_EMIT: begin
        emit_req = |mask;
        emit_cmd.command = sel_cmd;
        emit_cmd.voice   = (sel_cmd == CMD_OFF) ? off_voice : 5'(target);
        emit_cmd.last    = 1'b0;
        case (sel_cmd)
          CMD_OFF:    emit_cmd.value = {7'd0, off_note};
          CMD_TIMBRE: emit_cmd.value = {7'd0, patch_l};
          CMD_VOLUME: emit_cmd.value = {7'd0, loud};
          CMD_PITCH:  emit_cmd.value = bend_l;
          default:    emit_cmd.value = {7'd0, note_n};
        endcase
      end
      S_DONE: flush = hold_valid;
      default: ;
    endcase
  end

  assign stall = (emit_req || flush) && hold_valid && !can_push;
  assign push  = (emit_req || flush) && hold_valid && can_push;
  assign shift = ((state == S_SCAN) && !stall) || (state == S_WRITE);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (push) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  // the held command is final when it leaves on the flush
  always_ff @(posedge clk) begin
    if (push) begin
      cmd <= '{hold.command, hold.voice, hold.value, flush};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (emit_req && !stall) begin
      hold_valid <= 1'b1;
    end else if (flush && !stall) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && !stall) hold <= emit_cmd;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      drum_channel <= 4'd15;
    end else if (cfg_we) begin
      drum_channel <= cfg_data;
    end
  end

  // channel tables, updated on message transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
        channel_patch[i] <= '0;
        channel_bend[i]  <= BEND_CENTER;
      end
    end else if (msg_valid && msg_ready) begin
      if (msg.kind == KIND_RESET) begin
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
          channel_patch[i] <= '0;
          channel_bend[i]  <= BEND_CENTER;
        end
      end else if (msg.channel != drum_channel) begin
        if (msg.kind == KIND_PROGRAM) channel_patch[msg.channel] <= msg.data_one;
        if (msg.kind == KIND_BEND)    channel_bend[msg.channel]  <= bend_msg;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      age_counter <= '0;
      mask        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (msg_valid) begin
            if (msg.kind == KIND_RESET) begin
              mode <= M_REL_ALL; state <= S_SCAN;
            end else if (msg.kind <= KIND_BEND && msg.channel != drum_channel) begin
              case (msg.kind) inside
                KIND_NOTE_OFF, KIND_NOTE_ON: begin
                  mode <= M_FIND; state <= S_SCAN;
                end
                KIND_CONTROL: begin
                  if (msg.data_one >= CTRL_ALL_OFF) begin
                    mode <= M_REL_ALL; state <= S_SCAN;
                  end else begin
                    state <= S_DONE;
                  end
                end
                KIND_PROGRAM: begin
                  mode <= M_REL_CH; state <= S_SCAN;
                end
                default: begin
                  mode <= M_BEND; state <= S_SCAN;
                end
              endcase
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (shift) begin
            idx    <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
            found  <= found_next;  fidx  <= fidx_next;   fvol <= fvol_next;
            free   <= free_next;   pick  <= pick_next;   pnote <= pnote_next;
            pvol   <= pvol_next;   oldest <= oldest_next;
            if (idx == LAST_IDX) begin
              if (mode == M_FIND && (found_next || is_on)) begin
                // matched voice, or a new one taken
                state     <= S_WRITE;
                mask      <= scan_mask;
                target    <= found_next ? fidx_next : pick_next;
                off_voice <= 5'(found_next ? fidx_next : pick_next);
                off_note  <= found_next ? note_n : pnote_next;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_WRITE: begin
          idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
          if (idx == LAST_IDX) begin
            age_counter <= age_counter + 32'd1;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (mask == '0) begin
            state <= S_DONE;
          end else if (!stall) begin
            mask[sel_cmd] <= 1'b0;
          end
        end
        S_DONE: begin
          if (!stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // message fields latched on transfer
  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      ch      <= msg.channel;
      is_on   <= (msg.kind == KIND_NOTE_ON) && (msg.data_two != 7'd0);
      note_n  <= shift_note(channel_patch[msg.channel], msg.data_one);
      loud    <= boost(msg.data_two);
      patch_l <= channel_patch[msg.channel];
      bend_l  <= (msg.kind == KIND_BEND) ? bend_msg : channel_bend[msg.channel];
    end
  end

endmodule

@@ design/mva_cell.sv @@
module mva_cell
  import mva_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  voice_t d,
  output voice_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ design/mva_checker.sv @@
module mva_props
  import mva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input cmd_t       cmd
);

  // stalled command holds
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command changed while stalled");

  // message port closes only on a transfer
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(msg_ready) |-> $past(msg_valid))
    else $error("ready dropped without transfer");

  // a non-final command on the port means the message is still in progress
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd.last |-> !msg_ready)
    else $error("message taken before final command");

  a_voice_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> {1'b0, cmd.voice} < 6'(NUM_VOICES))
    else $error("voice index out of range");

endmodule

bind midi_voice_allocator mva_props #(.NUM_VOICES(NUM_VOICES)) u_mva_props (.*);
